FILE: design/kvt_pkg.sv
// Shared constants, codes and types for the key-value table.
`timescale 1ns / 1ps
package kvt_pkg;

   localparam int CAPACITY    = 256;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;

   localparam int REQ_FIELD_BITS = CMD_BITS + KEY_BITS + VALUE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STATUS_BITS + VALUE_BITS + CNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_BITS-1:0] CMD_PUT    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd2;

   typedef enum logic [1:0] {
      OP_PUT,
      OP_GET,
      OP_DELETE,
      OP_NONE
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_REPLACED  = 3'd0,
      STATUS_REUSED    = 3'd1,
      STATUS_APPENDED  = 3'd2,
      STATUS_FOUND     = 3'd3,
      STATUS_EMPTY     = 3'd4,
      STATUS_NOT_FOUND = 3'd5,
      STATUS_FULL      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_SCAN,
      BS_APPLY
   } back_state_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

endpackage

FILE: design/key_value_table_tombstone.sv
// Top level of the key-value table with deleted-slot reuse.
`timescale 1ns / 1ps
// Each request is a put, get or delete of a 32-bit key, answered by exactly one
// response carrying a status, the read value and the live entry count. Requests
// are taken into a two-entry queue while the table engine works, so the request
// side keeps flowing for up to three requests ahead. The engine reads the key
// and value memories through a single read port, one slot per cycle, from slot
// zero up to the high-water mark, stopping at the first live match. The scan
// covers at most the high-water mark of slots (256 at most) and is skipped when
// the table has never been written.
module key_value_table_tombstone (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command [1:0], key [33:2], value [65:34], zero fill above
   input  logic [kvt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [2:0], read_value [34:3], live_entries [43:35], zero fill above
   output logic [kvt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import kvt_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   kvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   kvt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_cmd   (pop_cmd)
   );

   kvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/kvt_front.sv
// Request intake: register the request and classify its command.
`timescale 1ns / 1ps
module kvt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kvt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              push_valid,
   input  logic                              push_ready,
   output kvt_pkg::cmd_type                  push_cmd
);
   import kvt_pkg::*;

   logic    slot_valid_ff, slot_valid_in;
   cmd_type slot_ff, slot_in;
   op_type  op;
   logic    accept;

   always_comb begin
      unique case (req_tdata[CMD_BITS-1:0])
         CMD_PUT:    op = OP_PUT;
         CMD_GET:    op = OP_GET;
         CMD_DELETE: op = OP_DELETE;
         default:    op = OP_NONE;
      endcase
   end

   assign req_tready = !slot_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = slot_valid_ff;
   assign push_cmd   = slot_ff;

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      if (accept) begin
         slot_in.op    = op;
         slot_in.key   = req_tdata[CMD_BITS +: KEY_BITS];
         slot_in.value = req_tdata[CMD_BITS + KEY_BITS +: VALUE_BITS];
         slot_valid_in = 1'b1;
      end else if (push_ready) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

FILE: design/kvt_queue.sv
// Short request queue between intake and table engine.
`timescale 1ns / 1ps
module kvt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kvt_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output kvt_pkg::cmd_type out_cmd
);
   import kvt_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: design/kvt_back.sv
// Table engine: scan the key store one slot per cycle and apply the request.
`timescale 1ns / 1ps
module kvt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  kvt_pkg::cmd_type                  cmd,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kvt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import kvt_pkg::*;

   localparam logic [CNT_BITS-1:0] CAPACITY_COUNT = CNT_BITS'(CAPACITY);

   logic [KEY_BITS-1:0]   key_mem_ff [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem_ff [CAPACITY];
   logic [CAPACITY-1:0]   del_ff, del_in;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CNT_BITS-1:0]   hw_ff, hw_in;
   logic [CNT_BITS-1:0]   live_ff, live_in;
   logic [CNT_BITS-1:0]   addr_ff, addr_in;
   logic                  pipe_valid_ff, pipe_valid_in;
   logic [IDX_BITS-1:0]   pipe_idx_ff;
   logic                  pipe_del_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                  start, issue, match, last, finish, out_free, commit;
   logic [IDX_BITS-1:0]   rd_idx;
   logic                  key_wr_en, val_wr_en;
   logic [IDX_BITS-1:0]   wr_idx;
   status_type            status;
   logic [VALUE_BITS-1:0] read_value;

   assign rd_idx   = addr_ff[IDX_BITS-1:0];
   assign issue    = addr_ff < hw_ff;
   assign match    = pipe_valid_ff && !pipe_del_ff && (key_rd_ff == cmd_ff.key);
   assign last     = pipe_valid_ff && (CNT_BITS'({1'b0, pipe_idx_ff} + 1'b1) == hw_ff);
   assign finish   = match || last;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign start    = (state_ff == BS_IDLE) && cmd_valid;
   assign commit   = (state_ff == BS_APPLY) && out_free;
   assign cmd_ready = state_ff == BS_IDLE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BS_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op != OP_NONE && hw_ff != '0) begin
                  state_in = BS_SCAN;
               end else begin
                  state_in = BS_APPLY;
               end
            end
         end
         BS_SCAN: begin
            if (finish) begin
               state_in = BS_APPLY;
            end
         end
         BS_APPLY: begin
            if (out_free) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      pipe_valid_in = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      if (start) begin
         cmd_in  = cmd;
         addr_in = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (state_ff == BS_SCAN) begin
         pipe_valid_in = issue && !finish;
         addr_in       = issue ? CNT_BITS'(addr_ff + 1'b1) : addr_ff;
         if (pipe_valid_ff && pipe_del_ff && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = pipe_idx_ff;
         end
         if (match) begin
            hit_in     = 1'b1;
            hit_idx_in = pipe_idx_ff;
            hit_val_in = val_rd_ff;
         end
      end
   end

   always_comb begin
      status     = STATUS_NOT_FOUND;
      read_value = '0;
      hw_in      = hw_ff;
      live_in    = live_ff;
      del_in     = del_ff;
      key_wr_en  = 1'b0;
      val_wr_en  = 1'b0;
      wr_idx     = hit_idx_ff;
      unique case (cmd_ff.op)
         OP_PUT: begin
            if (hit_ff) begin
               status    = STATUS_REPLACED;
               val_wr_en = 1'b1;
            end else if (free_ff) begin
               status              = STATUS_REUSED;
               key_wr_en           = 1'b1;
               val_wr_en           = 1'b1;
               wr_idx              = free_idx_ff;
               del_in[free_idx_ff] = 1'b0;
               live_in             = CNT_BITS'(live_ff + 1'b1);
            end else if (hw_ff < CAPACITY_COUNT) begin
               status                       = STATUS_APPENDED;
               key_wr_en                    = 1'b1;
               val_wr_en                    = 1'b1;
               wr_idx                       = hw_ff[IDX_BITS-1:0];
               del_in[hw_ff[IDX_BITS-1:0]]  = 1'b0;
               hw_in                        = CNT_BITS'(hw_ff + 1'b1);
               live_in                      = CNT_BITS'(live_ff + 1'b1);
            end else begin
               status = STATUS_FULL;
            end
         end
         OP_GET, OP_DELETE: begin
            if (hw_ff == '0) begin
               status = STATUS_EMPTY;
            end else if (hit_ff) begin
               status     = STATUS_FOUND;
               read_value = hit_val_ff;
               if (cmd_ff.op == OP_DELETE) begin
                  del_in[hit_idx_ff] = 1'b1;
                  if (live_ff != '0) begin
                     live_in = CNT_BITS'(live_ff - 1'b1);
                  end
               end
            end
         end
         default: status = STATUS_NOT_FOUND;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, live_in, read_value, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BS_IDLE;
         hw_ff         <= '0;
         live_ff       <= '0;
         del_ff        <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (commit) begin
            hw_ff   <= hw_in;
            live_ff <= live_in;
            del_ff  <= del_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
      pipe_idx_ff <= rd_idx;
      pipe_del_ff <= del_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (commit && key_wr_en) begin
         key_mem_ff[wr_idx] <= cmd_ff.key;
      end
      if (commit && val_wr_en) begin
         val_mem_ff[wr_idx] <= cmd_ff.value;
      end
      key_rd_ff <= key_mem_ff[rd_idx];
      val_rd_ff <= val_mem_ff[rd_idx];
   end

endmodule
